/* src/blrl_pkg.sv */
// ----------------------------------------------------------------------------
// blrl_pkg
// Shared types and constants for the relocating loader: character codes,
// the parse phase encoding and the token passed from the front to the back.
// ----------------------------------------------------------------------------
package blrl_pkg;

	localparam int unsigned WORD_W = 24;
	localparam int unsigned POS_W  = 4;

	localparam logic [7:0] CHAR_T     = 8'h54;  // 'T'
	localparam logic [7:0] CHAR_CARET = 8'h5E;  // '^'
	localparam logic [7:0] CHAR_ZERO  = 8'h30;  // '0'

	localparam logic [POS_W-1:0] POS_ADDR_FIRST = 4'd2;
	localparam logic [POS_W-1:0] POS_ADDR_LAST  = 4'd7;
	localparam logic [POS_W-1:0] POS_HEAD_END   = 4'd12;
	localparam logic [POS_W-1:0] POS_WORD_END   = 4'd6;

	localparam logic [WORD_W-1:0] ADDR_STEP = 24'd3;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_SKIP,
		PH_HEAD,
		PH_MASK,
		PH_SEP,
		PH_WORD
	} phase_t;

	// One classified character.
	typedef struct packed {
		logic       blank;
		logic       is_t;
		logic       caret;
		logic       zero;
		logic [3:0] hex;
	} token_t;

	// Head of the queue as seen by the back end.
	typedef struct packed {
		logic   valid;
		token_t tok;
	} tok_link_t;

endpackage

/* src/blrl_front.sv */
// ----------------------------------------------------------------------------
// blrl_front
// Accepts characters, classifies them into tokens and holds them in a short
// queue until the back end takes them.
// ----------------------------------------------------------------------------
module blrl_front import blrl_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      char_valid,
	output logic      char_stall,
	input  logic [7:0] char_in,
	output tok_link_t head,
	input  logic      pop
);

	localparam int unsigned DEPTH = 4;
	localparam int unsigned PTR_W = 2;

	token_t             fifo_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [PTR_W:0]     count_q;
	token_t             tok_new;
	logic               push;
	logic               do_pop;

	always_comb begin
		tok_new.blank = 1'b0;
		case (char_in) inside
			8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D, 8'h20: tok_new.blank = 1'b1;
			default: tok_new.blank = 1'b0;
		endcase
		tok_new.is_t  = (char_in == CHAR_T);
		tok_new.caret = (char_in == CHAR_CARET);
		tok_new.zero  = (char_in == CHAR_ZERO);
		case (char_in) inside
			[8'h30:8'h39]: tok_new.hex = char_in[3:0];
			[8'h41:8'h46],
			[8'h61:8'h66]: tok_new.hex = char_in[3:0] + 4'd9;
			default:       tok_new.hex = 4'd0;
		endcase
	end

	assign char_stall = (count_q == (PTR_W+1)'(DEPTH));
	assign push       = char_valid && !char_stall;
	assign do_pop     = pop && (count_q != '0);

	assign head.valid = (count_q != '0);
	assign head.tok   = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= tok_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

/* src/blrl_back.sv */
// ----------------------------------------------------------------------------
// blrl_back
// Record parser: unless the output stalls, walks the header, mask and words of
// text records one token per cycle; finished words load the output register.
// ----------------------------------------------------------------------------
module blrl_back import blrl_pkg::*; #(
	parameter int unsigned MASK_BITS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  tok_link_t         head,
	output logic              pop,
	input  logic [WORD_W-1:0] base,
	output logic              res_valid,
	input  logic              res_stall,
	output logic [WORD_W-1:0] load_address,
	output logic [WORD_W-1:0] word_value,
	output logic              was_relocated
);

	localparam int unsigned CNT_W = $clog2(MASK_BITS + 1);
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MASK_BITS);

	phase_t               phase_q, phase_d;
	logic [POS_W-1:0]     pos_q, pos_d;
	logic [WORD_W-1:0]    acc_q, acc_d;
	logic [WORD_W-1:0]    addr_q, addr_d;
	logic [MASK_BITS-1:0] mask_q, mask_d;
	logic [CNT_W-1:0]     mlen_q, mlen_d;
	logic [CNT_W-1:0]     widx_q, widx_d;

	logic                 res_valid_q;
	logic [WORD_W-1:0]    res_addr_q;
	logic [WORD_W-1:0]    res_word_q;
	logic                 res_rel_q;

	token_t               tok;
	logic                 adv;
	logic                 emit;
	logic [WORD_W-1:0]    acc_sh;
	logic [POS_W-1:0]     pos_inc;
	logic [MASK_BITS-1:0] mask_sh;
	logic                 rel;

	assign tok     = head.tok;
	assign adv     = head.valid && (!res_valid_q || !res_stall);
	assign pop     = adv;
	assign acc_sh  = {acc_q[WORD_W-5:0], tok.hex};
	assign pos_inc = pos_q + 1'b1;
	assign mask_sh = mask_q >> widx_q;
	assign rel     = (widx_q < mlen_q) && mask_sh[0];

	// Next phase.
	always_comb begin
		phase_d = phase_q;
		if (tok.blank) begin
			phase_d = PH_IDLE;
		end else begin
			case (phase_q)
				PH_IDLE: phase_d = tok.is_t ? PH_HEAD : PH_SKIP;
				PH_HEAD: phase_d = (pos_inc >= POS_HEAD_END) ? PH_MASK : PH_HEAD;
				PH_MASK: phase_d = tok.caret ? PH_SEP : PH_MASK;
				PH_SEP:  phase_d = tok.caret ? PH_SEP : PH_WORD;
				PH_WORD: phase_d = (pos_inc < POS_WORD_END) ? PH_WORD : PH_SEP;
				default: phase_d = phase_q;
			endcase
		end
	end

	// Datapath updates and word emission.
	always_comb begin
		pos_d  = pos_q;
		acc_d  = acc_q;
		addr_d = addr_q;
		mask_d = mask_q;
		mlen_d = mlen_q;
		widx_d = widx_q;
		emit   = 1'b0;
		if (tok.blank) begin
			pos_d = '0;
			acc_d = '0;
		end else begin
			case (phase_q)
				PH_IDLE: begin
					if (tok.is_t) begin
						pos_d  = 4'd1;
						acc_d  = '0;
						mask_d = '0;
						mlen_d = '0;
						widx_d = '0;
					end
				end
				PH_HEAD: begin
					if (pos_q >= POS_ADDR_FIRST && pos_q <= POS_ADDR_LAST) begin
						acc_d = acc_sh;
						if (pos_q == POS_ADDR_LAST) begin
							addr_d = acc_sh + base;
						end
					end
					pos_d = (pos_inc >= POS_HEAD_END) ? '0 : pos_inc;
				end
				PH_MASK: begin
					if (!tok.caret && mlen_q < CNT_MAX) begin
						if (!tok.zero) begin
							mask_d = mask_q | (MASK_BITS'(1) << mlen_q);
						end
						mlen_d = mlen_q + 1'b1;
					end
				end
				PH_SEP: begin
					if (!tok.caret) begin
						acc_d = {{(WORD_W-4){1'b0}}, tok.hex};
						pos_d = 4'd1;
					end
				end
				PH_WORD: begin
					if (pos_inc < POS_WORD_END) begin
						acc_d = acc_sh;
						pos_d = pos_inc;
					end else begin
						emit   = 1'b1;
						acc_d  = '0;
						pos_d  = '0;
						addr_d = addr_q + ADDR_STEP;
						if (widx_q < CNT_MAX) begin
							widx_d = widx_q + 1'b1;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			pos_q       <= '0;
			acc_q       <= '0;
			addr_q      <= '0;
			mask_q      <= '0;
			mlen_q      <= '0;
			widx_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				phase_q <= phase_d;
				pos_q   <= pos_d;
				acc_q   <= acc_d;
				addr_q  <= addr_d;
				mask_q  <= mask_d;
				mlen_q  <= mlen_d;
				widx_q  <= widx_d;
			end
			if (adv && emit) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && emit) begin
			res_addr_q <= addr_q;
			res_word_q <= rel ? acc_sh + base : acc_sh;
			res_rel_q  <= rel;
		end
	end

	assign res_valid     = res_valid_q;
	assign load_address  = res_addr_q;
	assign word_value    = res_word_q;
	assign was_relocated = res_rel_q;

endmodule

/* src/bitmask_relocating_loader.sv */
// Path: a word's last character enters the token queue, then passes from the
//   queue head into the result register; a stalled output can hold it back.
// Throughput: one character per cycle while the queue is not full; the parser
//   retires one queued token per cycle, pausing only while a result is stalled.
// Reset: arst_n clears the parser, the character queue and the output valid;
//   the relocation base resets to zero.
// ----------------------------------------------------------------------------
// bitmask_relocating_loader
// Relocating loader for text records with a relocation bit mask. A front end
// classifies incoming characters and queues them; a back end parses records
// and delivers relocated words through a registered output.
// ----------------------------------------------------------------------------
module bitmask_relocating_loader import blrl_pkg::*; #(
	parameter int unsigned MASK_BITS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	// configuration write channel
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [WORD_W-1:0] relocation_base,
	// character request channel
	input  logic              char_valid,
	output logic              char_stall,
	input  logic [7:0]        char_in,
	// result request channel
	output logic              res_valid,
	input  logic              res_stall,
	output logic [WORD_W-1:0] load_address,
	output logic [WORD_W-1:0] word_value,
	output logic              was_relocated
);

	logic [WORD_W-1:0] base_q;
	tok_link_t         head;
	logic              pop;

	// The base register takes every write; the user must write it only while idle.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			base_q <= relocation_base;
		end
	end

	// Front: classify each character and hold it in the token queue.
	blrl_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.char_valid (char_valid),
		.char_stall (char_stall),
		.char_in    (char_in),
		.head       (head),
		.pop        (pop)
	);

	// Back: parse records and drive the result register.
	blrl_back #(
		.MASK_BITS (MASK_BITS)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head          (head),
		.pop           (pop),
		.base          (base_q),
		.res_valid     (res_valid),
		.res_stall     (res_stall),
		.load_address  (load_address),
		.word_value    (word_value),
		.was_relocated (was_relocated)
	);

endmodule
